// ===== rtl/sarh_pkg.sv =====
// ----------------------------------------------------------------------------
// sarh_pkg
// Shared types and codes for the sampled address range histogram: record
// kinds, classified operations, the queued request and the control state.
// ----------------------------------------------------------------------------
package sarh_pkg;

    localparam int KIND_W      = 3;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 64;
    localparam int SLOT_W      = 6;
    localparam int CFG_W       = 7;
    localparam int OUT_COUNT_W = 32;

    // Record kinds as they arrive on the input channel
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IGNORE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

    // Smallest well-formed sample record, in bytes
    localparam logic [SIZE_W-1:0] MIN_SAMPLE_BYTES = 16'd16;

    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_IGNORE,
        OP_HALT,
        OP_LOAD,
        OP_READ
    } sarh_op_t;

    // Classified request as it waits in the queue
    typedef struct packed {
        sarh_op_t            op;
        logic                size_short;
        logic                slot_ok;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   boundary;
    } sarh_item_t;

    // Queue head seen by the back end
    typedef struct packed {
        logic       valid;
        sarh_item_t item;
    } sarh_queue_t;

    // Back end control toward the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } sarh_back_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HI,
        ST_LO,
        ST_SCAN,
        ST_COUNT,
        ST_READ
    } sarh_state_t;

endpackage

// ===== rtl/sampled_address_range_histogram_core.sv =====
// ----------------------------------------------------------------------------
// sampled_address_range_histogram_core
// Counts sampled instruction addresses into ranges set by an ascending
// boundary table; also loads boundaries and reads back bin counters.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+------------------------------------------
//   input    | in_valid / in_ready | kind, record_size, sample_address,
//            |                     | entry_index, boundary_value
//   result   | out_valid/out_ready | counted, bin_index, count_value,
//            |                     | size_short, halted
//   config   | cfg_we              | boundary_count
//
// Load, ignored, unknown and halted-sample requests, and samples with under
// two boundaries, finish in the idle state; a counter read goes on to the
// read state. An in-range sample reads the top and bottom boundaries, takes
// k bin-scan steps (zero with two boundaries, at most n-2), limited by the
// single read port of the boundary memory, and then counts; a sample outside
// the table range ends at the top or bottom compare. After reset the counter
// memory is cleared, with in_ready low. A two-entry queue and the result
// register let the input keep flowing while a result waits on out_ready.
// ----------------------------------------------------------------------------
module sampled_address_range_histogram_core
    import sarh_pkg::*;
#(
    parameter int MAX_BOUNDARIES = 64,
    parameter int COUNT_WIDTH    = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        boundary_count,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [KIND_W-1:0]       kind,
    input  logic [SIZE_W-1:0]       record_size,
    input  logic [ADDR_W-1:0]       sample_address,
    input  logic [SLOT_W-1:0]       entry_index,
    input  logic [ADDR_W-1:0]       boundary_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    counted,
    output logic [SLOT_W-1:0]       bin_index,
    output logic [OUT_COUNT_W-1:0]  count_value,
    output logic                    size_short,
    output logic                    halted
);

    sarh_queue_t    head;
    sarh_back_ctl_t ctl;

    // Intake, classification and queue
    sarh_front #(
        .MAX_BOUNDARIES (MAX_BOUNDARIES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .record_size    (record_size),
        .sample_address (sample_address),
        .entry_index    (entry_index),
        .boundary_value (boundary_value),
        .head           (head),
        .ctl            (ctl)
    );

    // Execution: bin scan, counters, result register
    sarh_back #(
        .MAX_BOUNDARIES (MAX_BOUNDARIES),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .boundary_count (boundary_count),
        .head           (head),
        .ctl            (ctl),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .counted        (counted),
        .bin_index      (bin_index),
        .count_value    (count_value),
        .size_short     (size_short),
        .halted         (halted)
    );

endmodule

// ===== rtl/sarh_front.sv =====
// ----------------------------------------------------------------------------
// sarh_front
// Accepts records, classifies them into operations and holds them in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module sarh_front
    import sarh_pkg::*;
#(
    parameter int MAX_BOUNDARIES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [SIZE_W-1:0]    record_size,
    input  logic [ADDR_W-1:0]    sample_address,
    input  logic [SLOT_W-1:0]    entry_index,
    input  logic [ADDR_W-1:0]    boundary_value,
    output sarh_queue_t          head,
    input  sarh_back_ctl_t       ctl
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    sarh_item_t         item_in;
    sarh_item_t         q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    // Classify the incoming record
    always_comb
    begin
        item_in.size_short = (record_size < MIN_SAMPLE_BYTES);
        item_in.slot_ok    = ({{(32-SLOT_W){1'b0}}, entry_index} < 32'(MAX_BOUNDARIES));
        item_in.slot       = entry_index;
        item_in.address    = sample_address;
        item_in.boundary   = boundary_value;
        case (kind)
            KIND_SAMPLE:  item_in.op = OP_SAMPLE;
            KIND_IGNORE:  item_in.op = OP_IGNORE;
            KIND_UNKNOWN: item_in.op = OP_HALT;
            KIND_LOAD:    item_in.op = OP_LOAD;
            KIND_READ:    item_in.op = OP_READ;
            default:      item_in.op = OP_IGNORE;
        endcase
    end

    // Hold off intake while the queue is full or counters are being cleared
    assign in_ready = (count_reg != QCNT_W'(QDEPTH)) && !ctl.clearing;
    assign push     = in_valid && in_ready;
    assign pop      = ctl.pop;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/sarh_back.sv =====
// ----------------------------------------------------------------------------
// sarh_back
// Carries out queued requests: scans the boundary table for a sample's bin,
// updates the saturating bin counter, loads boundaries and reads counters.
// ----------------------------------------------------------------------------
module sarh_back
    import sarh_pkg::*;
#(
    parameter int MAX_BOUNDARIES = 64,
    parameter int COUNT_WIDTH    = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_W-1:0]         boundary_count,
    input  sarh_queue_t              head,
    output sarh_back_ctl_t           ctl,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     counted,
    output logic [SLOT_W-1:0]        bin_index,
    output logic [OUT_COUNT_W-1:0]   count_value,
    output logic                     size_short,
    output logic                     halted
);

    localparam int AW = $clog2(MAX_BOUNDARIES);
    localparam int NW = $clog2(MAX_BOUNDARIES + 1);

    sarh_state_t state_reg;
    sarh_state_t state_next;

    logic [CFG_W-1:0]        bc_reg;
    logic                    halt_reg;
    logic                    halt_next;
    logic [AW-1:0]           idx_reg;
    logic [AW-1:0]           idx_next;
    logic [AW-1:0]           bin_reg;
    logic [AW-1:0]           bin_next;
    logic [AW-1:0]           clr_reg;
    logic [AW-1:0]           clr_next;
    sarh_item_t              cur_reg;
    sarh_item_t              cur_next;

    // Boundary table and counter memories
    logic [ADDR_W-1:0]       bnd_mem [MAX_BOUNDARIES];
    logic [ADDR_W-1:0]       bnd_rdata_reg;
    logic                    bnd_we;
    logic [AW-1:0]           bnd_waddr;
    logic [ADDR_W-1:0]       bnd_wdata;
    logic                    bnd_re;
    logic [AW-1:0]           bnd_raddr;
    logic [COUNT_WIDTH-1:0]  cnt_mem [MAX_BOUNDARIES];
    logic [COUNT_WIDTH-1:0]  cnt_rdata_reg;
    logic                    cnt_we;
    logic [AW-1:0]           cnt_waddr;
    logic [COUNT_WIDTH-1:0]  cnt_wdata;
    logic                    cnt_re;
    logic [AW-1:0]           cnt_raddr;

    // Result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    counted_reg;
    logic [SLOT_W-1:0]       bin_index_reg;
    logic [OUT_COUNT_W-1:0]  count_value_reg;
    logic                    size_short_reg;
    logic                    halted_reg;

    // Result of the current step
    logic                    emit;
    logic                    e_counted;
    logic [AW-1:0]           e_bin;
    logic [OUT_COUNT_W-1:0]  e_count;
    logic                    e_short;

    logic [NW-1:0]           n_val;
    logic [NW-1:0]           n_last;
    logic                    n_ok;
    logic                    more;
    logic                    ge;
    logic                    emit_ok;
    logic                    cnt_full;
    logic                    wide_hi;
    logic [OUT_COUNT_W-1:0]  read_val;
    logic [AW-1:0]           hit_bin;

    // Effective boundary count, clamped to the table size
    assign n_val    = ({{(32-CFG_W){1'b0}}, bc_reg} > 32'(MAX_BOUNDARIES))
                    ? NW'(MAX_BOUNDARIES) : NW'(bc_reg);
    assign n_last   = n_val - 1'b1;
    assign n_ok     = (n_val >= NW'(2));
    assign more     = ((NW'(idx_reg) + 1'b1) < n_last);
    assign ge       = (cur_reg.address >= bnd_rdata_reg);
    assign hit_bin  = ge ? idx_reg : idx_reg - 1'b1;
    assign emit_ok  = !out_valid_reg || out_ready;
    assign cnt_full = &cnt_rdata_reg;
    assign wide_hi  = (COUNT_WIDTH > OUT_COUNT_W) && ((cnt_rdata_reg >> OUT_COUNT_W) != '0);
    assign read_val = wide_hi ? '1 : OUT_COUNT_W'(cnt_rdata_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(MAX_BOUNDARIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.item.op == OP_SAMPLE && !halt_reg && n_ok)
                    begin
                        state_next = ST_HI;
                    end
                    else if (head.item.op == OP_READ && head.item.slot_ok)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_HI:
            begin
                if (!ge)
                begin
                    state_next = ST_LO;
                end
                else if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LO:
            begin
                if (!ge)
                begin
                    if (emit_ok)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (n_val == NW'(2))
                begin
                    state_next = ST_COUNT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!(ge && more))
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT, ST_READ:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        ctl.pop      = 1'b0;
        ctl.clearing = (state_reg == ST_CLEAR);
        bnd_we       = 1'b0;
        bnd_waddr    = '0;
        bnd_wdata    = head.item.boundary;
        bnd_re       = 1'b0;
        bnd_raddr    = '0;
        cnt_we       = 1'b0;
        cnt_waddr    = bin_reg;
        cnt_wdata    = cnt_rdata_reg + 1'b1;
        cnt_re       = 1'b0;
        cnt_raddr    = '0;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        bin_next     = bin_reg;
        halt_next    = halt_reg;
        clr_next     = clr_reg;
        emit         = 1'b0;
        e_counted    = 1'b0;
        e_bin        = '0;
        e_count      = '0;
        e_short      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.item.op)
                        OP_SAMPLE:
                        begin
                            if (!halt_reg && n_ok)
                            begin
                                // Start the scan with the top boundary
                                ctl.pop   = 1'b1;
                                cur_next  = head.item;
                                bnd_re    = 1'b1;
                                bnd_raddr = AW'(n_last);
                            end
                            else if (emit_ok)
                            begin
                                ctl.pop = 1'b1;
                                emit    = 1'b1;
                                e_short = !halt_reg && head.item.size_short;
                            end
                        end
                        OP_HALT:
                        begin
                            if (emit_ok)
                            begin
                                ctl.pop   = 1'b1;
                                emit      = 1'b1;
                                halt_next = 1'b1;
                            end
                        end
                        OP_LOAD:
                        begin
                            if (emit_ok)
                            begin
                                ctl.pop   = 1'b1;
                                emit      = 1'b1;
                                bnd_we    = head.item.slot_ok;
                                bnd_waddr = AW'(head.item.slot);
                            end
                        end
                        OP_READ:
                        begin
                            if (head.item.slot_ok)
                            begin
                                ctl.pop   = 1'b1;
                                cnt_re    = 1'b1;
                                cnt_raddr = AW'(head.item.slot);
                            end
                            else if (emit_ok)
                            begin
                                ctl.pop = 1'b1;
                                emit    = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (emit_ok)
                            begin
                                ctl.pop = 1'b1;
                                emit    = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_HI:
            begin
                if (ge)
                begin
                    emit    = emit_ok;
                    e_short = cur_reg.size_short;
                end
                else
                begin
                    bnd_re    = 1'b1;
                    bnd_raddr = '0;
                end
            end
            ST_LO:
            begin
                if (!ge)
                begin
                    emit    = emit_ok;
                    e_short = cur_reg.size_short;
                end
                else if (n_val == NW'(2))
                begin
                    bin_next  = '0;
                    cnt_re    = 1'b1;
                    cnt_raddr = '0;
                end
                else
                begin
                    bnd_re    = 1'b1;
                    bnd_raddr = AW'(1);
                    idx_next  = AW'(1);
                end
            end
            ST_SCAN:
            begin
                if (ge && more)
                begin
                    bnd_re    = 1'b1;
                    bnd_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    bin_next  = hit_bin;
                    cnt_re    = 1'b1;
                    cnt_raddr = hit_bin;
                end
            end
            ST_COUNT:
            begin
                if (emit_ok)
                begin
                    // Increment unless already saturated
                    cnt_we    = !cnt_full;
                    emit      = 1'b1;
                    e_counted = 1'b1;
                    e_bin     = bin_reg;
                    e_short   = cur_reg.size_short;
                end
            end
            ST_READ:
            begin
                emit    = emit_ok;
                e_count = read_val;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            bc_reg        <= '0;
            halt_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halt_reg      <= halt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                bc_reg <= boundary_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        bin_reg <= bin_next;
        if (emit)
        begin
            counted_reg     <= e_counted;
            bin_index_reg   <= SLOT_W'(e_bin);
            count_value_reg <= e_count;
            size_short_reg  <= e_short;
            halted_reg      <= halt_next;
        end
    end

    // Boundary table
    always_ff @(posedge clk)
    begin
        if (bnd_we)
        begin
            bnd_mem[bnd_waddr] <= bnd_wdata;
        end
        if (bnd_re)
        begin
            bnd_rdata_reg <= bnd_mem[bnd_raddr];
        end
    end

    // Bin counters
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign counted     = counted_reg;
    assign bin_index   = bin_index_reg;
    assign count_value = count_value_reg;
    assign size_short  = size_short_reg;
    assign halted      = halted_reg;

endmodule

// ===== rtl/sarh_checker.sv =====
// ----------------------------------------------------------------------------
// sarh_checker
// Port-level checks on the histogram result channel.
// ----------------------------------------------------------------------------
module sarh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        counted,
    input logic [5:0]  bin_index,
    input logic [31:0] count_value,
    input logic        size_short,
    input logic        halted
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(counted)
            && $stable(bin_index) && $stable(count_value))
        else $error("result changed while stalled");

    // A counted sample never comes after halt
    a_counted_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && counted |-> !halted)
        else $error("sample counted while halted");

    // Bin index is zero unless a bin was hit
    a_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !counted |-> bin_index == 6'd0)
        else $error("bin index set without a hit");

    // Only a counter read returns a count value
    a_count_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_value != 32'd0 |-> !counted && !size_short)
        else $error("count value on a sample result");

endmodule

bind sampled_address_range_histogram_core sarh_checker u_sarh_checker (.*);
